// ===== rtl/rv32x_pkg.sv =====
// Package: opcode and function codes and the per-item result record of the executor.
`timescale 1ns / 1ps
`default_nettype none

package rv32x_pkg;

   localparam logic [6:0] OPC_OP_IMM = 7'h13;
   localparam logic [6:0] OPC_LOAD   = 7'h03;
   localparam logic [6:0] OPC_STORE  = 7'h23;
   localparam logic [6:0] OPC_LUI    = 7'd55;
   localparam logic [6:0] OPC_OP     = 7'h33;
   localparam logic [6:0] OPC_BRANCH = 7'h63;
   localparam logic [6:0] OPC_JAL    = 7'b1101111;

   localparam logic [2:0] F3_ADD  = 3'd0;
   localparam logic [2:0] F3_SLL  = 3'd1;
   localparam logic [2:0] F3_WORD = 3'd2;
   localparam logic [2:0] F3_BGE  = 3'd5;

   localparam logic [6:0] F7_ZERO = 7'd0;

   typedef struct packed {
      logic [31:0] executed_at;
      logic [31:0] next_address;
      logic        reg_written;
      logic [4:0]  dest_index;
      logic [31:0] dest_value;
      logic        is_load;
      logic [31:0] mem_address;
      logic        store_done;
      logic [31:0] store_address;
      logic [31:0] store_value;
      logic        unsupported;
   } res_type;

endpackage

`default_nettype wire

// ===== rtl/rv32x_rf.sv =====
// Register file: 32 x 32 bits, two registered write-first read ports, per-entry valid bits.
`timescale 1ns / 1ps
`default_nettype none

module rv32x_rf (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic [4:0]  read_addr_a,
   input  wire logic [4:0]  read_addr_b,
   output logic      [31:0] read_data_a,
   output logic      [31:0] read_data_b,
   input  wire logic        write_enable,
   input  wire logic [4:0]  write_addr,
   input  wire logic [31:0] write_data
);

   logic [31:0] rf_mem [32];
   logic [31:0] vld_ff;
   logic [31:0] vld_in;
   logic [31:0] rdata_a_ff;
   logic [31:0] rdata_b_ff;
   logic [31:0] rdata_a_in;
   logic [31:0] rdata_b_in;

   always_comb begin
      vld_in = vld_ff;
      if (write_enable) begin
         vld_in[write_addr] = 1'b1;
      end
   end

   // entries never written read as zero; same-edge write is passed through
   always_comb begin
      rdata_a_in = vld_ff[read_addr_a] ? rf_mem[read_addr_a] : '0;
      rdata_b_in = vld_ff[read_addr_b] ? rf_mem[read_addr_b] : '0;
      if (write_enable && (write_addr == read_addr_a)) begin
         rdata_a_in = write_data;
      end
      if (write_enable && (write_addr == read_addr_b)) begin
         rdata_b_in = write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (write_enable) begin
         rf_mem[write_addr] <= write_data;
      end
      rdata_a_ff <= rdata_a_in;
      rdata_b_ff <= rdata_b_in;
   end

   assign read_data_a = rdata_a_ff;
   assign read_data_b = rdata_b_ff;

endmodule

`default_nettype wire

// ===== rtl/rv32x_widx.sv =====
// Word index unit: (word address) mod DATA_WORDS by reciprocal multiply over two stages.
`timescale 1ns / 1ps
`default_nettype none

module rv32x_widx #(
   parameter int DATA_WORDS = 1024
) (
   input  wire logic                          clock,
   input  wire logic                          load_enable,
   input  wire logic [29:0]                   word_address,
   output logic      [$clog2(DATA_WORDS)-1:0] word_index
);

   localparam int          IDX_W = $clog2(DATA_WORDS);
   localparam logic [31:0] RECIP = 32'((64'd1 << 32) / DATA_WORDS);
   localparam logic [29:0] DW30  = 30'(DATA_WORDS);

   logic [29:0] addr_ff;
   logic [29:0] quot_ff;
   logic [29:0] quot_in;
   logic [61:0] prod;
   logic [29:0] qd;
   logic [29:0] rem;
   logic [29:0] rem_fix;

   // estimate is the true quotient or one less
   assign prod    = 62'(word_address) * 62'(RECIP);
   assign quot_in = prod[61:32];

   always_ff @(posedge clock) begin
      if (load_enable) begin
         addr_ff <= word_address;
         quot_ff <= quot_in;
      end
   end

   assign qd         = quot_ff * DW30;
   assign rem        = addr_ff - qd;
   assign rem_fix    = (rem >= DW30) ? (rem - DW30) : rem;
   assign word_index = rem_fix[IDX_W-1:0];

endmodule

`default_nettype wire

// ===== rtl/rv32i_subset_executor.sv =====
// Top level: four-stage RV32I subset executor with register file and data memory.
//
// Usage:
//   req_* carries one instruction word per item (valid/ready). rsp_* returns one
//   result item per instruction, in order (valid/ready). csr_write_enable with
//   csr_write_data loads the program counter; write it only while idle.
// Stages: an accepted instruction passes execute, index multiply, index reduce and
//   memory access, then its result is presented from the result register.
// Throughput: one instruction per cycle unless a load wait, the sweep or rsp_ready
//   stalls. An item reading the destination of a load one or two items ahead waits
//   for the load data from the registered data memory read in the third stage.
// Reset: the pc becomes 0, registers read as zero, and the data memory is swept
//   to zero one word per cycle, all DATA_WORDS words; req_ready stays low then.
// Stall: when rsp_ready is low the result register holds; earlier stages keep
//   filling; req_ready drops only once all four stages are full or a load wait holds.
`timescale 1ns / 1ps
`default_nettype none

module rv32i_subset_executor
   import rv32x_pkg::*;
#(
   parameter int DATA_WORDS = 1024
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [31:0] req_instruction_word,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic      [31:0] rsp_executed_at,
   output logic      [31:0] rsp_next_address,
   output logic             rsp_reg_written,
   output logic      [4:0]  rsp_dest_index,
   output logic      [31:0] rsp_dest_value,
   output logic             rsp_store_done,
   output logic      [31:0] rsp_store_address,
   output logic      [31:0] rsp_store_value,
   output logic             rsp_unsupported,
   input  wire logic        csr_write_enable,
   input  wire logic [31:0] csr_write_data
);

   localparam int IDX_W = $clog2(DATA_WORDS);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DATA_WORDS - 1);

   // control
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic s1_valid_in, s2_valid_in, s3_valid_in, s4_valid_in;
   logic clr_busy_ff, clr_busy_in;
   logic [IDX_W-1:0] clr_idx_ff, clr_idx_in;
   logic [31:0] pc_ff, pc_in;
   logic s1_go, s2_go, s3_go;
   logic s1_free, s2_free, s3_free, s4_free;
   logic req_fire, hazard;

   // payload
   logic [31:0] s1_instr_ff;
   logic [31:0] s1_pc_ff;
   logic [31:0] s1_pc_in;
   res_type     s1_res;
   res_type     s2_res_ff, s3_res_ff, s4_res_ff;
   logic [31:0] mem_rdata_ff;
   logic [31:0] s4_value;

   // execute stage
   logic [6:0]  opc;
   logic [4:0]  rd, rs1, rs2;
   logic [2:0]  f3;
   logic [6:0]  f7;
   logic [31:0] rf_a, rf_b, op_a, op_b;
   logic [31:0] imm_i, imm_s, imm_b, imm_j, pc_plus4;
   logic        wr, ld;
   logic [31:0] val;
   logic [4:0]  rf_ra, rf_rb;
   logic        rf_we;

   // data memory
   logic [31:0]      dmem [DATA_WORDS];
   logic [IDX_W-1:0] s3_idx;
   logic             dmem_we;
   logic [IDX_W-1:0] dmem_waddr;
   logic [31:0]      dmem_wdata;

   // handshake chain
   assign s4_free   = !s4_valid_ff || rsp_ready;
   assign s3_go     = s3_valid_ff && s4_free;
   assign s3_free   = !s3_valid_ff || s4_free;
   assign s2_go     = s2_valid_ff && s3_free;
   assign s2_free   = !s2_valid_ff || s3_free;
   assign s1_go     = s1_valid_ff && !hazard && s2_free;
   assign s1_free   = !s1_valid_ff || s1_go;
   assign req_ready = s1_free && !clr_busy_ff;
   assign req_fire  = req_valid && req_ready;

   assign s1_valid_in = (s1_valid_ff && !s1_go) || req_fire;
   assign s2_valid_in = (s2_valid_ff && !s2_go) || s1_go;
   assign s3_valid_in = (s3_valid_ff && !s3_go) || s2_go;
   assign s4_valid_in = (s4_valid_ff && !(s4_valid_ff && rsp_ready)) || s3_go;

   assign clr_busy_in = clr_busy_ff && (clr_idx_ff != LAST_IDX);
   assign clr_idx_in  = clr_busy_ff ? (clr_idx_ff + 1'b1) : clr_idx_ff;

   always_comb begin
      pc_in = pc_ff;
      if (csr_write_enable) begin
         pc_in = csr_write_data;
      end else if (s1_go) begin
         pc_in = s1_res.next_address;
      end
   end

   assign s1_pc_in = s1_go ? s1_res.next_address : pc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         clr_busy_ff <= 1'b1;
         clr_idx_ff  <= '0;
         pc_ff       <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
         s4_valid_ff <= s4_valid_in;
         clr_busy_ff <= clr_busy_in;
         clr_idx_ff  <= clr_idx_in;
         pc_ff       <= pc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_instr_ff <= req_instruction_word;
         s1_pc_ff    <= s1_pc_in;
      end
      if (s1_go) begin
         s2_res_ff <= s1_res;
      end
      if (s2_go) begin
         s3_res_ff <= s2_res_ff;
      end
      if (s3_go) begin
         s4_res_ff <= s3_res_ff;
      end
   end

   // register file, reread every cycle for the item held in execute
   assign rf_ra = req_fire ? req_instruction_word[19:15] : s1_instr_ff[19:15];
   assign rf_rb = req_fire ? req_instruction_word[24:20] : s1_instr_ff[24:20];
   assign rf_we = s4_valid_ff && rsp_ready && s4_res_ff.reg_written;

   rv32x_rf u_rf (
      .clock        (clock),
      .reset        (reset),
      .read_addr_a  (rf_ra),
      .read_addr_b  (rf_rb),
      .read_data_a  (rf_a),
      .read_data_b  (rf_b),
      .write_enable (rf_we),
      .write_addr   (s4_res_ff.dest_index),
      .write_data   (s4_value)
   );

   assign s4_value = s4_res_ff.is_load ? mem_rdata_ff : s4_res_ff.dest_value;

   // field split
   assign opc = s1_instr_ff[6:0];
   assign rd  = s1_instr_ff[11:7];
   assign f3  = s1_instr_ff[14:12];
   assign rs1 = s1_instr_ff[19:15];
   assign rs2 = s1_instr_ff[24:20];
   assign f7  = s1_instr_ff[31:25];

   assign imm_i = {{20{s1_instr_ff[31]}}, s1_instr_ff[31:20]};
   assign imm_s = {{20{s1_instr_ff[31]}}, s1_instr_ff[31:25], s1_instr_ff[11:7]};
   assign imm_b = {{19{s1_instr_ff[31]}}, s1_instr_ff[31], s1_instr_ff[7],
                   s1_instr_ff[30:25], s1_instr_ff[11:8], 1'b0};
   assign imm_j = {{11{s1_instr_ff[31]}}, s1_instr_ff[31], s1_instr_ff[19:12],
                   s1_instr_ff[20], s1_instr_ff[30:21], 1'b0};
   assign pc_plus4 = s1_pc_ff + 32'd4;

   // load results are not ready before the result stage
   assign hazard = (s2_valid_ff && s2_res_ff.is_load &&
                    ((s2_res_ff.dest_index == rs1) || (s2_res_ff.dest_index == rs2))) ||
                   (s3_valid_ff && s3_res_ff.is_load &&
                    ((s3_res_ff.dest_index == rs1) || (s3_res_ff.dest_index == rs2)));

   // bypass, youngest writer wins
   always_comb begin
      op_a = rf_a;
      op_b = rf_b;
      if (s4_valid_ff && s4_res_ff.reg_written && (s4_res_ff.dest_index == rs1)) begin
         op_a = s4_value;
      end
      if (s4_valid_ff && s4_res_ff.reg_written && (s4_res_ff.dest_index == rs2)) begin
         op_b = s4_value;
      end
      if (s3_valid_ff && s3_res_ff.reg_written && (s3_res_ff.dest_index == rs1)) begin
         op_a = s3_res_ff.dest_value;
      end
      if (s3_valid_ff && s3_res_ff.reg_written && (s3_res_ff.dest_index == rs2)) begin
         op_b = s3_res_ff.dest_value;
      end
      if (s2_valid_ff && s2_res_ff.reg_written && (s2_res_ff.dest_index == rs1)) begin
         op_a = s2_res_ff.dest_value;
      end
      if (s2_valid_ff && s2_res_ff.reg_written && (s2_res_ff.dest_index == rs2)) begin
         op_b = s2_res_ff.dest_value;
      end
   end

   always_comb begin
      s1_res              = '0;
      s1_res.executed_at  = s1_pc_ff;
      s1_res.next_address = pc_plus4;
      wr                  = 1'b0;
      ld                  = 1'b0;
      val                 = '0;
      unique case (opc)
         OPC_OP_IMM: begin
            if (f3 == F3_ADD) begin
               wr  = 1'b1;
               val = op_a + imm_i;
            end else if ((f3 == F3_SLL) && (f7 == F7_ZERO)) begin
               wr  = 1'b1;
               val = op_a << s1_instr_ff[24:20];
            end else begin
               s1_res.unsupported = 1'b1;
            end
         end
         OPC_LOAD: begin
            if (f3 == F3_WORD) begin
               wr                 = 1'b1;
               ld                 = 1'b1;
               s1_res.mem_address = op_a + imm_i;
            end else begin
               s1_res.unsupported = 1'b1;
            end
         end
         OPC_STORE: begin
            if (f3 == F3_WORD) begin
               s1_res.store_done    = 1'b1;
               s1_res.store_address = op_a + imm_s;
               s1_res.store_value   = op_b;
               s1_res.mem_address   = op_a + imm_s;
            end else begin
               s1_res.unsupported = 1'b1;
            end
         end
         OPC_LUI: begin
            wr  = 1'b1;
            val = {s1_instr_ff[31:12], 12'd0};
         end
         OPC_OP: begin
            if ((f3 == F3_ADD) && (f7 == F7_ZERO)) begin
               wr  = 1'b1;
               val = op_a + op_b;
            end else begin
               s1_res.unsupported = 1'b1;
            end
         end
         OPC_BRANCH: begin
            if (f3 == F3_BGE) begin
               if ($signed(op_a) >= $signed(op_b)) begin
                  s1_res.next_address = s1_pc_ff + imm_b;
               end
            end else begin
               s1_res.unsupported = 1'b1;
            end
         end
         OPC_JAL: begin
            wr                  = 1'b1;
            val                 = pc_plus4;
            s1_res.next_address = s1_pc_ff + imm_j;
         end
         default: begin
            s1_res.unsupported = 1'b1;
         end
      endcase
      if (wr && (rd != 5'd0)) begin
         s1_res.reg_written = 1'b1;
         s1_res.dest_index  = rd;
         s1_res.dest_value  = val;
         s1_res.is_load     = ld;
      end
   end

   // word index: multiply in stage 2, reduce in stage 3
   rv32x_widx #(
      .DATA_WORDS (DATA_WORDS)
   ) u_widx (
      .clock        (clock),
      .load_enable  (s2_go),
      .word_address (s2_res_ff.mem_address[31:2]),
      .word_index   (s3_idx)
   );

   assign dmem_we    = clr_busy_ff || (s3_go && s3_res_ff.store_done);
   assign dmem_waddr = clr_busy_ff ? clr_idx_ff : s3_idx;
   assign dmem_wdata = clr_busy_ff ? '0 : s3_res_ff.store_value;

   always_ff @(posedge clock) begin
      if (dmem_we) begin
         dmem[dmem_waddr] <= dmem_wdata;
      end
      if (s3_go) begin
         mem_rdata_ff <= dmem[s3_idx];
      end
   end

   assign rsp_valid         = s4_valid_ff;
   assign rsp_executed_at   = s4_res_ff.executed_at;
   assign rsp_next_address  = s4_res_ff.next_address;
   assign rsp_reg_written   = s4_res_ff.reg_written;
   assign rsp_dest_index    = s4_res_ff.dest_index;
   assign rsp_dest_value    = s4_value;
   assign rsp_store_done    = s4_res_ff.store_done;
   assign rsp_store_address = s4_res_ff.store_address;
   assign rsp_store_value   = s4_res_ff.store_value;
   assign rsp_unsupported   = s4_res_ff.unsupported;

   a_hazard_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && hazard) |=> (s1_valid_ff && $stable(s1_instr_ff)))
      else $error("execute item lost during load wait");

   a_no_store_in_sweep: assert property (@(posedge clock) disable iff (reset)
      (s3_go && s3_res_ff.store_done) |-> !clr_busy_ff)
      else $error("store during memory sweep");

   a_quiet_dest: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_reg_written) |-> ((rsp_dest_index == 5'd0) && (rsp_dest_value == '0)))
      else $error("destination fields set without register write");

   a_no_x0_write: assert property (@(posedge clock) disable iff (reset)
      rf_we |-> (s4_res_ff.dest_index != 5'd0))
      else $error("write to x0");

endmodule

`default_nettype wire
